>>> sv/dcia_pkg.sv
package dcia_pkg;

	localparam int ID_CAPACITY_DEF = 63;
	localparam int ID_W            = 6;
	localparam int PTR_W           = 7;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_REMOVE = 2'd1,
		OP_COMMIT = 2'd2,
		OP_NEXT   = 2'd3
	} op_t;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_FULL          = 3'd1;
	localparam logic [2:0] ST_NOT_ALLOCATED = 3'd2;
	localparam logic [2:0] ST_NOT_COMMITTED = 3'd3;
	localparam logic [2:0] ST_END           = 3'd4;

	localparam logic [1:0] EV_PLAIN   = 2'd0;
	localparam logic [1:0] EV_DELETED = 2'd1;
	localparam logic [1:0] EV_CREATED = 2'd2;

	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] id;
		logic            id_ok;
	} cmd_t;

endpackage

>>> sv/dcia_front.sv
module dcia_front #(
	parameter int ID_CAPACITY = dcia_pkg::ID_CAPACITY_DEF
) (
	input  logic [1:0]               operation,
	input  logic [dcia_pkg::ID_W-1:0] target_id,
	output dcia_pkg::cmd_t           cmd
);

	localparam logic [dcia_pkg::ID_W-1:0] CAP_ID = dcia_pkg::ID_W'(ID_CAPACITY);

	dcia_pkg::op_t op;

	assign op = dcia_pkg::op_t'(operation);

	// remove needs an id in range, next-live needs a cursor below the top id
	always_comb begin
		cmd.op = op;
		cmd.id = target_id;
		unique case (op)
			dcia_pkg::OP_REMOVE: cmd.id_ok = (target_id != '0) && (target_id <= CAP_ID);
			dcia_pkg::OP_NEXT:   cmd.id_ok = (target_id < CAP_ID);
			default:             cmd.id_ok = 1'b1;
		endcase
	end

endmodule

>>> sv/dcia_queue.sv
module dcia_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dcia_pkg::cmd_t push_cmd,
	input  logic           pop,
	output dcia_pkg::cmd_t head_cmd,
	output logic           empty,
	output logic           full
);

	dcia_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign empty    = (count_q == 2'd0);
	assign full     = (count_q == 2'd2);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

>>> sv/dcia_back.sv
module dcia_back #(
	parameter int ID_CAPACITY = dcia_pkg::ID_CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dcia_pkg::cmd_t            head_cmd,
	input  logic                      empty,
	output logic                      pop,
	output logic                      valid,
	output logic [2:0]                status,
	output logic [dcia_pkg::ID_W-1:0] result_id,
	output logic [1:0]                event_kind,
	output logic                      last
);

	localparam int IDX_W = $clog2(ID_CAPACITY + 1);
	localparam logic [dcia_pkg::PTR_W-1:0] CAP_P  = dcia_pkg::PTR_W'(ID_CAPACITY);
	localparam logic [dcia_pkg::PTR_W-1:0] FULL_P = dcia_pkg::PTR_W'(ID_CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADV,
		S_DEL,
		S_CRE,
		S_NEXT
	} state_t;

	state_t                      state_q;
	logic [ID_CAPACITY:1]        live_q;
	logic [ID_CAPACITY:1]        pend_q;
	logic [dcia_pkg::PTR_W-1:0]  fp_q;
	logic [dcia_pkg::PTR_W-1:0]  scan_q;
	logic                        free_found_q;

	logic                        scan_end;
	logic                        scan_live;
	logic                        scan_pend;
	logic                        head_live;
	logic                        head_pend;
	logic [dcia_pkg::PTR_W-1:0]  head_next;

	assign pop       = (state_q == S_IDLE) && !empty;
	assign scan_end  = (scan_q > CAP_P);
	assign scan_live = !scan_end && live_q[scan_q[IDX_W-1:0]];
	assign scan_pend = !scan_end && pend_q[scan_q[IDX_W-1:0]];
	assign head_live = head_cmd.id_ok && live_q[head_cmd.id[IDX_W-1:0]];
	assign head_pend = head_cmd.id_ok && pend_q[head_cmd.id[IDX_W-1:0]];
	assign head_next = dcia_pkg::PTR_W'(head_cmd.id) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			live_q       <= '0;
			pend_q       <= '0;
			fp_q         <= dcia_pkg::PTR_W'(1);
			scan_q       <= '0;
			free_found_q <= 1'b0;
			valid        <= 1'b0;
			status       <= dcia_pkg::ST_OK;
			result_id    <= '0;
			event_kind   <= dcia_pkg::EV_PLAIN;
			last         <= 1'b0;
		end else begin
			valid      <= 1'b0;
			status     <= dcia_pkg::ST_OK;
			result_id  <= '0;
			event_kind <= dcia_pkg::EV_PLAIN;
			last       <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						unique case (head_cmd.op)
							dcia_pkg::OP_CREATE: begin
								valid <= 1'b1;
								if (fp_q > CAP_P) begin
									status <= dcia_pkg::ST_FULL;
								end else begin
									result_id                 <= fp_q[dcia_pkg::ID_W-1:0];
									pend_q[fp_q[IDX_W-1:0]]   <= 1'b1;
									scan_q                    <= fp_q + 1'b1;
									state_q                   <= S_ADV;
								end
							end
							dcia_pkg::OP_REMOVE: begin
								valid <= 1'b1;
								priority if (!head_pend) begin
									status <= dcia_pkg::ST_NOT_ALLOCATED;
								end else if (!head_live) begin
									status <= dcia_pkg::ST_NOT_COMMITTED;
								end else begin
									pend_q[head_cmd.id[IDX_W-1:0]] <= 1'b0;
								end
							end
							dcia_pkg::OP_COMMIT: begin
								scan_q  <= dcia_pkg::PTR_W'(1);
								state_q <= S_DEL;
							end
							dcia_pkg::OP_NEXT: begin
								if (!head_cmd.id_ok) begin
									valid  <= 1'b1;
									status <= dcia_pkg::ST_END;
								end else begin
									scan_q  <= head_next;
									state_q <= S_NEXT;
								end
							end
							default: ;
						endcase
					end
				end
				S_ADV: begin
					if (scan_end || (!scan_live && !scan_pend)) begin
						fp_q    <= scan_q;
						state_q <= S_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_DEL: begin
					if (scan_end) begin
						scan_q       <= dcia_pkg::PTR_W'(1);
						free_found_q <= 1'b0;
						state_q      <= S_CRE;
					end else begin
						if (scan_live && !scan_pend) begin
							valid      <= 1'b1;
							result_id  <= scan_q[dcia_pkg::ID_W-1:0];
							event_kind <= dcia_pkg::EV_DELETED;
							last       <= 1'b0;
						end
						scan_q <= scan_q + 1'b1;
					end
				end
				S_CRE: begin
					if (scan_end) begin
						// closing item, new set becomes committed
						valid   <= 1'b1;
						live_q  <= pend_q;
						if (!free_found_q)
							fp_q <= FULL_P;
						state_q <= S_IDLE;
					end else begin
						if (!scan_live && scan_pend) begin
							valid      <= 1'b1;
							result_id  <= scan_q[dcia_pkg::ID_W-1:0];
							event_kind <= dcia_pkg::EV_CREATED;
							last       <= 1'b0;
						end
						if (!scan_pend && !free_found_q) begin
							fp_q         <= scan_q;
							free_found_q <= 1'b1;
						end
						scan_q <= scan_q + 1'b1;
					end
				end
				S_NEXT: begin
					if (scan_end) begin
						valid   <= 1'b1;
						status  <= dcia_pkg::ST_END;
						state_q <= S_IDLE;
					end else if (scan_live) begin
						valid     <= 1'b1;
						result_id <= scan_q[dcia_pkg::ID_W-1:0];
						state_q   <= S_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_event_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (event_kind != dcia_pkg::EV_PLAIN) |-> !last)
		else $error("commit event marked last");

	a_fp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fp_q >= dcia_pkg::PTR_W'(1)) && (fp_q <= FULL_P))
		else $error("free pointer out of range");

	a_fp_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && (fp_q <= CAP_P) |->
		!pend_q[fp_q[IDX_W-1:0]] && !live_q[fp_q[IDX_W-1:0]])
		else $error("free pointer names a used id");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !pop)
		else $error("queue popped while executing");

	a_commit_copies: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CRE) && scan_end |=> (live_q == pend_q))
		else $error("commit did not copy pending map");

endmodule

>>> sv/deferred_commit_id_allocator.sv
// Allocates ids 1..ID_CAPACITY with create, remove, commit and next-live commands. A command
// transfers when start is high and busy is low; a two-entry queue sits in front of the executor,
// so busy rises only when two commands are waiting. Each result appears for exactly one cycle
// with valid high and cannot be held off; last marks the final result of a command. Results
// come out strictly in command order. Create hands out the id at the free pointer, which then
// advances past every id in use, unless the create is refused as full; remove gives its result
// directly; next-live scans the ids above the cursor and ends with ST_END when no live id is
// found; commit visits one id per cycle over the deletion pass and then the creation pass,
// with the closing item at the end. The executor visits one id per cycle.
module deferred_commit_id_allocator #(
	parameter int ID_CAPACITY = dcia_pkg::ID_CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                operation,
	input  logic [dcia_pkg::ID_W-1:0] target_id,
	output logic                      valid,
	output logic [2:0]                status,
	output logic [dcia_pkg::ID_W-1:0] result_id,
	output logic [1:0]                event_kind,
	output logic                      last
);

	dcia_pkg::cmd_t in_cmd;
	dcia_pkg::cmd_t head_cmd;
	logic           q_empty;
	logic           q_full;
	logic           q_pop;
	logic           q_push;

	assign busy   = q_full;
	assign q_push = start && !q_full;

	dcia_front #(
		.ID_CAPACITY (ID_CAPACITY)
	) u_front (
		.operation (operation),
		.target_id (target_id),
		.cmd       (in_cmd)
	);

	dcia_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (in_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	dcia_back #(
		.ID_CAPACITY (ID_CAPACITY)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.empty      (q_empty),
		.pop        (q_pop),
		.valid      (valid),
		.status     (status),
		.result_id  (result_id),
		.event_kind (event_kind),
		.last       (last)
	);

endmodule

>>> verif/deferred_commit_id_allocator_tb.sv
`timescale 1ns / 1ps

module deferred_commit_id_allocator_tb;

	localparam int CAP = dcia_pkg::ID_CAPACITY_DEF;
	localparam int ID_W = dcia_pkg::ID_W;
	localparam int RANDOM_ITEMS = 285;
	localparam int SETTLE_CYCLES = 2 * CAP + 20;

	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] rid;
		logic [1:0]      kind;
		logic            last;
	} reply_t;

	typedef struct {
		dcia_pkg::op_t   op;
		logic [ID_W-1:0] eid;
		bit              typed;
		logic [2:0]      t_status;
		logic [ID_W-1:0] t_id;
	} row_t;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic [1:0]      operation;
	logic [ID_W-1:0] target_id;
	logic            valid;
	logic [2:0]      status;
	logic [ID_W-1:0] result_id;
	logic [1:0]      event_kind;
	logic            last;

	deferred_commit_id_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.target_id  (target_id),
		.valid      (valid),
		.status     (status),
		.result_id  (result_id),
		.event_kind (event_kind),
		.last       (last)
	);

	// own copy of the allocator state, bit 0 unused
	logic [CAP:0]    live_ids;
	logic [CAP:0]    pending_ids;
	int unsigned     free_ptr;
	logic [ID_W-1:0] top_id_handed;

	reply_t replies_due[$];
	reply_t due;

	int mismatches;
	int results_seen;
	int sent;
	int idle_pct;
	int op_count[4];
	int events_seen;
	int full_refusals;
	int remove_refusals;

	row_t plan [25] = '{
		'{dcia_pkg::OP_NEXT,   6'd0,  1, dcia_pkg::ST_END,           6'd0},
		'{dcia_pkg::OP_REMOVE, 6'd0,  1, dcia_pkg::ST_NOT_ALLOCATED, 6'd0},
		'{dcia_pkg::OP_REMOVE, 6'd63, 1, dcia_pkg::ST_NOT_ALLOCATED, 6'd0},
		'{dcia_pkg::OP_NEXT,   6'd63, 1, dcia_pkg::ST_END,           6'd0},
		'{dcia_pkg::OP_COMMIT, 6'd0,  1, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_CREATE, 6'd0,  1, dcia_pkg::ST_OK,            6'd1},
		'{dcia_pkg::OP_CREATE, 6'd42, 0, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_REMOVE, 6'd1,  1, dcia_pkg::ST_NOT_COMMITTED, 6'd0},
		'{dcia_pkg::OP_COMMIT, 6'd21, 0, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_NEXT,   6'd0,  0, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_NEXT,   6'd1,  0, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_NEXT,   6'd62, 1, dcia_pkg::ST_END,           6'd0},
		'{dcia_pkg::OP_REMOVE, 6'd1,  1, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_REMOVE, 6'd1,  1, dcia_pkg::ST_NOT_ALLOCATED, 6'd0},
		'{dcia_pkg::OP_CREATE, 6'd63, 0, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_NEXT,   6'd0,  0, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_COMMIT, 6'd63, 0, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_REMOVE, 6'd2,  1, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_REMOVE, 6'd3,  1, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_COMMIT, 6'd0,  0, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_NEXT,   6'd0,  1, dcia_pkg::ST_END,           6'd0},
		'{dcia_pkg::OP_CREATE, 6'd0,  1, dcia_pkg::ST_OK,            6'd1},
		'{dcia_pkg::OP_CREATE, 6'd63, 0, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_COMMIT, 6'd0,  0, dcia_pkg::ST_OK,            6'd0},
		'{dcia_pkg::OP_NEXT,   6'd63, 1, dcia_pkg::ST_END,           6'd0}
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic reply_t mk(input logic [2:0] st, input logic [ID_W-1:0] rid,
			input logic [1:0] kind, input logic lst);
		reply_t r;
		r.status = st;
		r.rid = rid;
		r.kind = kind;
		r.last = lst;
		return r;
	endfunction

	function automatic logic [ID_W-1:0] pick_set_id(input logic [CAP:0] map);
		logic [ID_W-1:0] found[$];
		for (int i = 1; i <= CAP; i++)
			if (map[i])
				found.push_back(ID_W'(i));
		if (found.size() == 0)
			return ID_W'($urandom_range(63));
		return found[$urandom_range(found.size() - 1)];
	endfunction

	task automatic clear_allocator();
		live_ids = '0;
		pending_ids = '0;
		free_ptr = 1;
		top_id_handed = '0;
	endtask

	task automatic allocator_step(input dcia_pkg::op_t op, input logic [ID_W-1:0] eid);
		int unsigned id;
		bit found;
		found = 0;
		case (op)
		dcia_pkg::OP_CREATE: begin
			if (free_ptr > CAP) begin
				full_refusals++;
				replies_due.push_back(mk(dcia_pkg::ST_FULL, '0, dcia_pkg::EV_PLAIN, 1'b1));
			end else begin
				id = free_ptr;
				pending_ids[id] = 1'b1;
				if (id > top_id_handed)
					top_id_handed = ID_W'(id);
				do
					free_ptr++;
				while (free_ptr <= CAP && (live_ids[free_ptr] || pending_ids[free_ptr]));
				replies_due.push_back(mk(dcia_pkg::ST_OK, ID_W'(id), dcia_pkg::EV_PLAIN, 1'b1));
			end
		end
		dcia_pkg::OP_REMOVE: begin
			if (eid < 1 || eid > CAP || !pending_ids[eid]) begin
				remove_refusals++;
				replies_due.push_back(mk(dcia_pkg::ST_NOT_ALLOCATED, '0,
					dcia_pkg::EV_PLAIN, 1'b1));
			end else if (!live_ids[eid]) begin
				remove_refusals++;
				replies_due.push_back(mk(dcia_pkg::ST_NOT_COMMITTED, '0,
					dcia_pkg::EV_PLAIN, 1'b1));
			end else begin
				pending_ids[eid] = 1'b0;
				replies_due.push_back(mk(dcia_pkg::ST_OK, '0, dcia_pkg::EV_PLAIN, 1'b1));
			end
		end
		dcia_pkg::OP_COMMIT: begin
			for (id = 1; id <= CAP; id++)
				if (live_ids[id] && !pending_ids[id]) begin
					events_seen++;
					replies_due.push_back(mk(dcia_pkg::ST_OK, ID_W'(id),
						dcia_pkg::EV_DELETED, 1'b0));
				end
			for (id = 1; id <= CAP; id++)
				if (!live_ids[id] && pending_ids[id]) begin
					events_seen++;
					replies_due.push_back(mk(dcia_pkg::ST_OK, ID_W'(id),
						dcia_pkg::EV_CREATED, 1'b0));
				end
			free_ptr = 1;
			while (free_ptr <= CAP && pending_ids[free_ptr])
				free_ptr++;
			live_ids = pending_ids;
			replies_due.push_back(mk(dcia_pkg::ST_OK, '0, dcia_pkg::EV_PLAIN, 1'b1));
		end
		default: begin
			for (id = eid + 1; id <= CAP && !found; id++)
				if (live_ids[id]) begin
					found = 1;
					replies_due.push_back(mk(dcia_pkg::ST_OK, ID_W'(id),
						dcia_pkg::EV_PLAIN, 1'b1));
				end
			if (!found)
				replies_due.push_back(mk(dcia_pkg::ST_END, '0, dcia_pkg::EV_PLAIN, 1'b1));
		end
		endcase
	endtask

	// called just after a rising edge; returns at the edge of the transfer
	task automatic send(input dcia_pkg::op_t op, input logic [ID_W-1:0] eid, input bit typed,
			input reply_t typed_reply);
		int gap;
		gap = 0;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct)
			gap = ($urandom_range(9) == 0) ? $urandom_range(20, 140) : $urandom_range(1, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		target_id <= eid;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		op_count[op]++;
		allocator_step(op, eid);
		if (typed) begin
			void'(replies_due.pop_back());
			replies_due.push_back(typed_reply);
		end
	endtask

	task automatic issue(input dcia_pkg::op_t op, input logic [ID_W-1:0] eid);
		send(op, eid, 1'b0, '0);
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (replies_due.size() != 0);
	endtask

	task automatic fill_up();
		while (free_ptr <= CAP)
			issue(dcia_pkg::OP_CREATE, ID_W'($urandom_range(63)));
		repeat ($urandom_range(1, 2))
			issue(dcia_pkg::OP_CREATE, ID_W'($urandom_range(63)));
	endtask

	task automatic random_round();
		int pick;
		int r;
		logic [CAP:0] snap;
		pick = $urandom_range(99);
		snap = live_ids & pending_ids;
		if (pick < 30) begin
			repeat ($urandom_range(1, 6))
				issue(dcia_pkg::OP_CREATE, ID_W'($urandom_range(63)));
		end else if (pick < 55) begin
			repeat ($urandom_range(1, 6)) begin
				r = $urandom_range(9);
				if (r < 6)
					issue(dcia_pkg::OP_REMOVE, pick_set_id(live_ids & pending_ids));
				else if (r < 8)
					issue(dcia_pkg::OP_REMOVE, pick_set_id(pending_ids));
				else
					issue(dcia_pkg::OP_REMOVE, ID_W'($urandom_range(63)));
			end
		end else if (pick < 72) begin
			issue(dcia_pkg::OP_COMMIT, ID_W'($urandom_range(63)));
		end else if (pick < 86) begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(1))
					issue(dcia_pkg::OP_NEXT, pick_set_id(live_ids) - ID_W'($urandom_range(1)));
				else
					issue(dcia_pkg::OP_NEXT, ID_W'($urandom_range(63)));
			end
		end else if (pick < 91) begin
			fill_up();
		end else if (pick < 94) begin
			// take every committed id out in one go
			for (int i = 1; i <= CAP; i++)
				if (snap[i])
					issue(dcia_pkg::OP_REMOVE, ID_W'(i));
			issue(dcia_pkg::OP_COMMIT, '0);
		end else begin
			repeat ($urandom_range(1, 3))
				issue(dcia_pkg::op_t'($urandom_range(3)), ID_W'($urandom_range(63)));
		end
	endtask

	task automatic note_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, field, want, got);
		end
	endtask

	// results are registered and stay for the whole cycle
	always @(negedge clk) begin
		if (arst_n && valid) begin
			results_seen++;
			if (replies_due.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected: status %0d id %0d kind %0d last %0d",
					$time, status, result_id, event_kind, last);
			end else begin
				due = replies_due.pop_front();
				note_field("status", 8'(due.status), 8'(status));
				note_field("result_id", 8'(due.rid), 8'(result_id));
				note_field("event_kind", 8'(due.kind), 8'(event_kind));
				note_field("last", 8'(due.last), 8'(last));
			end
		end
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int phase_pct[4];
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = dcia_pkg::OP_CREATE;
		target_id = '0;
		mismatches = 0;
		results_seen = 0;
		sent = 0;
		idle_pct = 0;
		events_seen = 0;
		full_refusals = 0;
		remove_refusals = 0;
		op_count = '{0, 0, 0, 0};
		phase_pct = '{0, 74, 0, 35};
		clear_allocator();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send(plan[i].op, plan[i].eid, plan[i].typed,
				mk(plan[i].t_status, plan[i].t_id, dcia_pkg::EV_PLAIN, 1'b1));
		wait_drain();

		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_pct[ph];
			if (ph == 0)
				fill_up();
			while (sent < (ph + 1) * RANDOM_ITEMS / 4)
				random_round();
			wait_drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("transfers: %0d create, %0d remove, %0d commit, %0d next-live; %0d results",
			op_count[dcia_pkg::OP_CREATE], op_count[dcia_pkg::OP_REMOVE],
			op_count[dcia_pkg::OP_COMMIT], op_count[dcia_pkg::OP_NEXT], results_seen);
		$display("commit events %0d, creates refused as full %0d, removes refused %0d",
			events_seen, full_refusals, remove_refusals);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> deferred_commit_id_allocator.f
sv/dcia_pkg.sv
sv/dcia_front.sv
sv/dcia_queue.sv
sv/dcia_back.sv
sv/deferred_commit_id_allocator.sv
verif/deferred_commit_id_allocator_tb.sv
